// ===== src/swerve_wheel_kinematics_defines.svh =====
// Assertion macros shared by the swerve wheel kinematics RTL.
`ifndef SWERVE_WHEEL_KINEMATICS_DEFINES_SVH
`define SWERVE_WHEEL_KINEMATICS_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SWK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SWK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/swk_pkg.sv =====
// Package with types, constants and the arctangent table of the wheel kinematics block.
package swk_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int OPD_W = 18;
	localparam int VEC_W = 20;
	localparam int MAG_W = 19;
	localparam int ANG_W = 16;
	localparam int MUL_STEPS = 16;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int ACC_W = 37;
	localparam int T_W = 17;
	localparam logic [ANG_W-1:0] ANGLE_QUARTER = 16'h4000;
	localparam logic [ANG_W-1:0] ANGLE_NEG_QUARTER = 16'hC000;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_HALF_LENGTH = 2'd0;
	localparam cfg_idx_t CFG_SPEED_SCALE = 2'd1;
	localparam cfg_idx_t CFG_TIMEOUT = 2'd2;

	typedef struct packed {
		logic active;
		logic signed [15:0] linear_x;
		logic signed [15:0] linear_y;
		logic signed [15:0] yaw_rate;
		logic [15:0] command_age_ms;
	} in_item_t;

	typedef struct packed {
		logic [15:0] speed_front_left;
		logic [15:0] speed_front_right;
		logic [15:0] speed_rear_left;
		logic [15:0] speed_rear_right;
		logic signed [15:0] angle_front_left;
		logic signed [15:0] angle_front_right;
		logic signed [15:0] angle_rear_left;
		logic signed [15:0] angle_rear_right;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TMUL,
		ST_TSUM,
		ST_CSTART,
		ST_CRUN,
		ST_SMUL,
		ST_SSTORE,
		ST_DONE
	} state_t;

	// atan(2^-i) scaled so that 32768 is pi.
	function automatic logic [ANG_W-1:0] atan_step(input logic [4:0] i);
		logic [ANG_W-1:0] r;
		unique case (i)
			5'd0: r = 16'd8192;
			5'd1: r = 16'd4836;
			5'd2: r = 16'd2555;
			5'd3: r = 16'd1297;
			5'd4: r = 16'd651;
			5'd5: r = 16'd326;
			5'd6: r = 16'd163;
			5'd7: r = 16'd81;
			5'd8: r = 16'd41;
			5'd9: r = 16'd20;
			5'd10: r = 16'd10;
			5'd11: r = 16'd5;
			5'd12: r = 16'd3;
			5'd13: r = 16'd1;
			5'd14: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/swk_cordic.sv =====
// Iterative vectoring CORDIC: magnitude and atan2 of one operand pair.
module swk_cordic (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [swk_pkg::OPD_W-1:0] p,
	input logic signed [swk_pkg::OPD_W-1:0] q,
	output logic done,
	output logic [swk_pkg::MAG_W-1:0] mag,
	output logic [swk_pkg::ANG_W-1:0] ang
);
	import swk_pkg::*;

	logic busy_q, done_q, zero_q;
	logic [STEP_W-1:0] i_q;
	logic signed [VEC_W-1:0] x_q, y_q, xe, ye, xs, ys;
	logic [ANG_W-1:0] z_q, tab;

	assign xe = VEC_W'(q);
	assign ye = VEC_W'(p);
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign tab = atan_step(5'(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && i_q == STEP_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			i_q <= '0;
			zero_q <= (p == '0) && (q == '0);
			// A vector in the left half plane is turned by a quarter first.
			if (xe < 0) begin
				if (ye >= 0) begin
					x_q <= ye;
					y_q <= -xe;
					z_q <= ANGLE_QUARTER;
				end else begin
					x_q <= -ye;
					y_q <= xe;
					z_q <= ANGLE_NEG_QUARTER;
				end
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (!y_q[VEC_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
		end
	end

	assign done = done_q;
	assign mag = (zero_q || x_q[VEC_W-1]) ? '0 : x_q[MAG_W-1:0];
	assign ang = zero_q ? '0 : z_q;

endmodule

// ===== src/swerve_wheel_kinematics.sv =====
// Swerve wheel kinematics: body velocity command in, four wheel speeds and angles out.
//
// Input items arrive on in_valid/in_ready with an in_item_t payload; results leave on
// out_valid/out_ready as an out_item_t. Registers are written over cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is always high and index 3 is ignored.
// An active item runs a bit-serial multiply for the yaw term, then for each wheel
// one 16-step CORDIC and a bit-serial speed scaling, one wheel after the other.
// Each wheel passes through CORDIC start, the CORDIC steps, CORDIC done, the
// multiply and the store. The CORDIC unit and the serial multiplier are shared by
// all wheels, and the multiplier also serves the yaw term. An inactive item gives
// its halt result through the done state, or no result if already halted.
// One item is worked on at a time: in_ready is high only while no item is in work.
// The result sits in an output register, so the next item is accepted while it waits;
// a finished item whose result cannot yet be written waits until out_ready frees it.
// Reset restores the register defaults, clears the halted flag and the held angles,
// and empties the output register.
module swerve_wheel_kinematics (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input swk_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output swk_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input swk_pkg::cfg_idx_t cfg_index,
	input logic [15:0] cfg_data
);
	import swk_pkg::*;
	`include "swerve_wheel_kinematics_defines.svh"

	state_t state_q, state_d;
	logic [11:0] half_length_q;
	logic [15:0] speed_scale_q, timeout_q;
	logic halted_q, out_valid_q;
	out_item_t out_q;
	logic [15:0] speeds_q [4];
	logic [ANG_W-1:0] angles_q [4];
	logic signed [15:0] x_q, y_q;
	logic signed [OPD_W-1:0] a_q, b_q, c_q, d_q;
	logic signed [ACC_W-1:0] acc_q, mcand_q, rnd;
	logic [15:0] mplier_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [1:0] k_q;
	logic accept, stale, out_free, mul_last, cor_start, cor_done;
	logic signed [15:0] x_eff, w_eff;
	logic signed [T_W-1:0] t;
	logic [ACC_W-13:0] sval;
	logic [15:0] speed_sat;
	logic [MAG_W-1:0] cor_mag;
	logic [ANG_W-1:0] cor_ang;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;
	assign mul_last = (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));
	assign cor_start = (state_q == ST_CSTART);

	assign stale = in_data.command_age_ms > timeout_q;
	assign x_eff = stale ? '0 : in_data.linear_x;
	assign w_eff = stale ? '0 : in_data.yaw_rate;

	assign rnd = acc_q + ACC_W'(2048);
	assign t = rnd[T_W+11:12];
	assign sval = rnd[ACC_W-1:12];
	assign speed_sat = (|sval[ACC_W-13:16]) ? 16'hFFFF : sval[15:0];

	swk_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.p(k_q[1] ? a_q : b_q),
		.q(k_q[0] ? c_q : d_q),
		.done(cor_done),
		.mag(cor_mag),
		.ang(cor_ang)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.active) state_d = ST_TMUL;
					else if (!halted_q) state_d = ST_DONE;
				end
			end
			ST_TMUL: if (mul_last) state_d = ST_TSUM;
			ST_TSUM: state_d = ST_CSTART;
			ST_CSTART: state_d = ST_CRUN;
			ST_CRUN: if (cor_done) state_d = ST_SMUL;
			ST_SMUL: if (mul_last) state_d = ST_SSTORE;
			ST_SSTORE: state_d = (k_q == 2'd3) ? ST_DONE : ST_CSTART;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			half_length_q <= 12'd250;
			speed_scale_q <= 16'd4096;
			timeout_q <= 16'd500;
			halted_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) angles_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_HALF_LENGTH: half_length_q <= cfg_data[11:0];
					CFG_SPEED_SCALE: speed_scale_q <= cfg_data;
					CFG_TIMEOUT: timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) halted_q <= !in_data.active;
			if (state_q == ST_SSTORE) angles_q[k_q] <= cor_ang;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q <= x_eff;
					y_q <= in_data.linear_y;
					acc_q <= '0;
					mcand_q <= {{(ACC_W-16){w_eff[15]}}, w_eff};
					mplier_q <= {4'd0, half_length_q};
					cnt_q <= '0;
					k_q <= '0;
					// The halt result carries zero speeds.
					for (int i = 0; i < 4; i++) speeds_q[i] <= '0;
				end
			end
			ST_TMUL, ST_SMUL: begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_TSUM: begin
				a_q <= OPD_W'(x_q) - OPD_W'(t);
				b_q <= OPD_W'(x_q) + OPD_W'(t);
				c_q <= OPD_W'(y_q) - OPD_W'(t);
				d_q <= OPD_W'(y_q) + OPD_W'(t);
			end
			ST_CRUN: begin
				acc_q <= '0;
				mcand_q <= {{(ACC_W-MAG_W){1'b0}}, cor_mag};
				mplier_q <= speed_scale_q;
				cnt_q <= '0;
			end
			ST_SSTORE: begin
				speeds_q[k_q] <= speed_sat;
				k_q <= k_q + 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.speed_front_left <= speeds_q[0];
					out_q.speed_front_right <= speeds_q[1];
					out_q.speed_rear_left <= speeds_q[2];
					out_q.speed_rear_right <= speeds_q[3];
					out_q.angle_front_left <= angles_q[0];
					out_q.angle_front_right <= angles_q[1];
					out_q.angle_rear_left <= angles_q[2];
					out_q.angle_rear_right <= angles_q[3];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`SWK_ASSERT_NXT(a_done_fills_out, state_q == ST_DONE && out_free, out_valid_q,
		"finished item did not reach the output register")
	`SWK_ASSERT_NXT(a_halted_no_result, accept && !in_data.active && halted_q,
		state_q == ST_IDLE, "repeated inactive item started work")
	`SWK_ASSERT_IMP(a_cordic_done_state, cor_done, state_q == ST_CRUN,
		"CORDIC finished outside its wait state")
	`SWK_ASSERT_NXT(a_active_clears_halt, accept && in_data.active, !halted_q,
		"active item left the halted flag set")

endmodule

// ===== test/swerve_wheel_kinematics_checker.sv =====
// Checker for the swerve wheel kinematics block: predicts each result and compares it.
module swerve_wheel_kinematics_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input swk_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input swk_pkg::out_item_t out_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input swk_pkg::cfg_idx_t cfg_index,
	input logic [15:0] cfg_data,
	output int fail_count,
	output int pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import swk_pkg::*;

	localparam int ATAN_LUT [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0};

	logic [11:0] half_len_reg;
	logic [15:0] scale_reg;
	logic [15:0] timeout_reg;
	logic halt_flag;
	logic [15:0] last_angles [4];
	out_item_t wheel_cmd_q [$];

	assign pending_count = wheel_cmd_q.size();

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// Vectoring CORDIC on (q, p) giving the magnitude and atan2(p, q).
	task automatic vector_wheel(input longint p, input longint q,
			output longint mag, output logic [15:0] ang);
		longint vx, vy, vz, tmp, sx, sy;
		vx = q;
		vy = p;
		vz = 0;
		if (p == 0 && q == 0) begin
			mag = 0;
			ang = '0;
			return;
		end
		if (vx < 0) begin
			tmp = vx;
			if (vy >= 0) begin
				vx = vy;
				vy = -tmp;
				vz = 16384;
			end else begin
				vx = -vy;
				vy = tmp;
				vz = -16384;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			sx = floor_shift(vx, i);
			sy = floor_shift(vy, i);
			if (vy >= 0) begin
				vx += sy;
				vy -= sx;
				vz += ATAN_LUT[i];
			end else begin
				vx -= sy;
				vy += sx;
				vz -= ATAN_LUT[i];
			end
		end
		mag = vx > 0 ? vx : 0;
		ang = vz[15:0];
	endtask

	task automatic predict_wheels(input in_item_t cmd);
		out_item_t res;
		longint lx, ly, yw, tt, pa, pb, pc, pd, mag, spd;
		longint pv [4], qv [4];
		logic [15:0] ang;
		logic [15:0] spds [4];
		if (!cmd.active) begin
			if (halt_flag) return;
			halt_flag = 1'b1;
			res = '0;
			res.angle_front_left = last_angles[0];
			res.angle_front_right = last_angles[1];
			res.angle_rear_left = last_angles[2];
			res.angle_rear_right = last_angles[3];
			wheel_cmd_q.insert(wheel_cmd_q.size(), res);
			return;
		end
		halt_flag = 1'b0;
		lx = cmd.linear_x;
		ly = cmd.linear_y;
		yw = cmd.yaw_rate;
		if (cmd.command_age_ms > timeout_reg) begin
			lx = 0;
			yw = 0;
		end
		tt = floor_shift(yw * longint'(half_len_reg) + 2048, 12);
		pa = lx - tt;
		pb = lx + tt;
		pc = ly - tt;
		pd = ly + tt;
		pv = '{pb, pb, pa, pa};
		qv = '{pd, pc, pd, pc};
		for (int k = 0; k < 4; k++) begin
			vector_wheel(pv[k], qv[k], mag, ang);
			spd = (mag * longint'(scale_reg) + 2048) >>> 12;
			spds[k] = spd > 65535 ? 16'hFFFF : spd[15:0];
			last_angles[k] = ang;
		end
		res.speed_front_left = spds[0];
		res.speed_front_right = spds[1];
		res.speed_rear_left = spds[2];
		res.speed_rear_right = spds[3];
		res.angle_front_left = last_angles[0];
		res.angle_front_right = last_angles[1];
		res.angle_rear_left = last_angles[2];
		res.angle_rear_right = last_angles[3];
		wheel_cmd_q.insert(wheel_cmd_q.size(), res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_len_reg <= 12'd250;
			scale_reg <= 16'd4096;
			timeout_reg <= 16'd500;
			halt_flag = 1'b0;
			last_angles = '{default: '0};
			wheel_cmd_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HALF_LENGTH: half_len_reg <= cfg_data[11:0];
					CFG_SPEED_SCALE: scale_reg <= cfg_data;
					CFG_TIMEOUT: timeout_reg <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (wheel_cmd_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result item %h", out_data);
				end else begin
					if (out_data !== wheel_cmd_q[0]) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected %h got %h",
								wheel_cmd_q[0], out_data);
					end
					void'(wheel_cmd_q.pop_front());
				end
			end
			if (in_valid && in_ready)
				predict_wheels(in_data);
		end
	end
endmodule

// ===== test/swerve_wheel_kinematics_tb.sv =====
// Testbench top for the swerve wheel kinematics block: stimulus, handshakes and verdict.
module swerve_wheel_kinematics_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swk_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = CFG_HALF_LENGTH;
	logic [15:0] cfg_data = '0;
	int fail_count;
	int pending_count;
	int cycle_count = 0;
	bit sink_busy = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	swerve_wheel_kinematics i_dut (.*);

	swerve_wheel_kinematics_checker i_checker (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random stall before each item, with stall-free stretches.
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = sink_busy ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Valid stays high after an accepted item when the next one follows at once.
	task automatic send_cmd(input in_item_t cmd, input bit idle_gap);
		int gap;
		gap = idle_gap ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= cmd;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stops sending, waits out all results, then leaves the block idle for a while.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	function automatic in_item_t make_cmd(logic act, logic [15:0] vx, logic [15:0] vy,
			logic [15:0] yw, logic [15:0] age);
		in_item_t c;
		c.active = act;
		c.linear_x = vx;
		c.linear_y = vy;
		c.yaw_rate = yw;
		c.command_age_ms = age;
		return c;
	endfunction

	function automatic logic [15:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		in_item_t cmd;
		logic [15:0] hl_set [4];
		logic [15:0] sc_set [4];
		logic [15:0] to_set [4];
		hl_set = '{16'd250, 16'd0, 16'd4095, 16'd1000};
		sc_set = '{16'd4096, 16'hFFFF, 16'd0, 16'd1234};
		to_set = '{16'd500, 16'd0, 16'hFFFF, 16'd100};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: halts, zero vectors, extremes, stale commands, pi wrap.
		send_cmd(make_cmd(1'b0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0);
		send_cmd(make_cmd(1'b0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0);
		send_cmd(make_cmd(1'b1, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0);
		send_cmd(make_cmd(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0), 1'b1);
		send_cmd(make_cmd(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'd500), 1'b1);
		send_cmd(make_cmd(1'b1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd501), 1'b1);
		send_cmd(make_cmd(1'b1, 16'd100, 16'hFF9C, 16'd0, 16'hFFFF), 1'b1);
		send_cmd(make_cmd(1'b1, 16'd0, 16'hFF9C, 16'd0, 16'd0), 1'b1);
		send_cmd(make_cmd(1'b1, 16'd0, 16'd100, 16'd0, 16'd0), 1'b1);
		send_cmd(make_cmd(1'b1, 16'hFF9C, 16'd0, 16'd0, 16'd0), 1'b1);
		send_cmd(make_cmd(1'b1, 16'd0, 16'd0, 16'h1000, 16'd10), 1'b1);
		send_cmd(make_cmd(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
		send_cmd(make_cmd(1'b0, 16'h1234, 16'd0, 16'd0, 16'd0), 1'b1);
		send_cmd(make_cmd(1'b1, 16'hFF9C, 16'hFF9C, 16'hF000, 16'd0), 1'b1);
		drain();
		write_reg(cfg_idx_t'(3), 16'hFFFF);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_reg(CFG_HALF_LENGTH, hl_set[ph]);
			write_reg(CFG_SPEED_SCALE, sc_set[ph]);
			write_reg(CFG_TIMEOUT, to_set[ph]);
			sink_busy = (ph != 2);
			for (int n = 0; n < 135; n++) begin
				cmd = make_cmd($urandom_range(0, 9) != 0, rand_field(), rand_field(),
					rand_field(), $urandom_range(0, 3) == 0 ? 16'($urandom) :
					16'($urandom_range(0, 1000)));
				if (n == 60)
					drain();
				send_cmd(cmd, ph != 2);
			end
		end

		drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
